@@ rtl/cse_pkg.sv @@
package cse_pkg;

  localparam int POS_BITS   = 32;
  localparam int READ_POS_W = 32;
  localparam int OUT_POS_W  = 32;
  localparam int CHROM_W    = 16;
  localparam int STRAND_W   = 2;
  localparam int OP_W       = 4;
  localparam int LEN_W      = 28;
  localparam int ANCHOR_W   = 16;
  localparam int INTRON_W   = 28;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 28;

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = '1;

  localparam logic [ANCHOR_W-1:0] MIN_ANCHOR_RST = ANCHOR_W'(8);
  localparam logic [INTRON_W-1:0] MIN_INTRON_RST = INTRON_W'(70);
  localparam logic [INTRON_W-1:0] MAX_INTRON_RST = INTRON_W'(500000);

  localparam logic [STRAND_W-1:0] STRAND_UNKNOWN  = 2'd2;
  localparam logic [STRAND_W-1:0] STRAND_RESERVED = 2'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_ANCHOR = 2'd0,
    CFG_MIN_INTRON = 2'd1,
    CFG_MAX_INTRON = 2'd2
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } cigar_op_t;

  typedef struct packed {
    logic [READ_POS_W-1:0] align_pos;
    logic [CHROM_W-1:0]    chrom_index;
    logic [STRAND_W-1:0]   strand_code;
    logic [OP_W-1:0]       op_code;
    logic [LEN_W-1:0]      op_length;
    logic                  first_op;
    logic                  last_op;
  } item_t;

  typedef struct packed {
    pos_t j_start;
    pos_t j_end;
    pos_t f_start;
    pos_t f_end;
  } junc_t;

  // Up to two junctions closed by one operation: a is the one closed by a skip,
  // b the one closed at the end of the read.
  typedef struct packed {
    logic                a_valid;
    logic                b_valid;
    junc_t               a;
    junc_t               b;
    logic [CHROM_W-1:0]  chrom;
    logic [STRAND_W-1:0] strand;
  } cand_t;

  function automatic pos_t clamp_pos(logic [READ_POS_W-1:0] p);
    logic [63:0] p64;
    p64 = 64'(p);
    if (p64 > 64'(POS_MAX)) begin
      return POS_MAX;
    end
    return pos_t'(p64);
  endfunction

  function automatic pos_t sat_add(pos_t a, logic [LEN_W-1:0] b);
    logic [POS_BITS:0] sum;
    sum = {1'b0, a} + (POS_BITS+1)'(b);
    if (sum[POS_BITS]) begin
      return POS_MAX;
    end
    return sum[POS_BITS-1:0];
  endfunction

  function automatic logic span_ok(junc_t j, logic [INTRON_W-1:0] mn,
                                   logic [INTRON_W-1:0] mx);
    logic [POS_BITS:0] d;
    pos_t              span;
    d    = {1'b0, j.j_end} - {1'b0, j.j_start};
    span = d[POS_BITS] ? '0 : d[POS_BITS-1:0];
    return (span >= pos_t'(mn)) && (span <= pos_t'(mx));
  endfunction

  // Overhang hi - lo, when non-negative, reaches the minimum anchor.
  function automatic logic anchored(pos_t hi, pos_t lo, logic [ANCHOR_W-1:0] a);
    logic [POS_BITS:0] d;
    d = {1'b0, hi} - {1'b0, lo};
    return !d[POS_BITS] && (d[POS_BITS-1:0] >= pos_t'(a));
  endfunction

endpackage

@@ rtl/cse_in_if.sv @@
interface cse_in_if
  import cse_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [READ_POS_W-1:0] align_pos;
  logic [CHROM_W-1:0]    chrom_index;
  logic [STRAND_W-1:0]   strand_code;
  logic [OP_W-1:0]       op_code;
  logic [LEN_W-1:0]      op_length;
  logic                  first_op;
  logic                  last_op;

  modport source (
    output valid, align_pos, chrom_index, strand_code, op_code, op_length,
           first_op, last_op,
    input  ready
  );

  modport sink (
    input  valid, align_pos, chrom_index, strand_code, op_code, op_length,
           first_op, last_op,
    output ready
  );
endinterface

@@ rtl/cse_out_if.sv @@
interface cse_out_if
  import cse_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CHROM_W-1:0]   junc_chrom;
  logic [STRAND_W-1:0]  junc_strand;
  logic [OUT_POS_W-1:0] junc_start;
  logic [OUT_POS_W-1:0] junc_end;
  logic [OUT_POS_W-1:0] flank_start;
  logic [OUT_POS_W-1:0] flank_end;
  logic                 left_anchored;
  logic                 right_anchored;
  logic                 last_of_run;

  modport source (
    output valid, junc_chrom, junc_strand, junc_start, junc_end, flank_start,
           flank_end, left_anchored, right_anchored, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, junc_chrom, junc_strand, junc_start, junc_end, flank_start,
           flank_end, left_anchored, right_anchored, last_of_run,
    output ready
  );
endinterface

@@ rtl/cigar_splice_junction_extractor_top.sv @@
// Channel   Dir  Handshake             Beat
// in_ch     in   valid/ready           one CIGAR operation with read context
// out_ch    out  valid/ready           one splice junction
// cfg_*     in   cfg_we, no back-press one register write, index in cfg_addr
//
// Three register stages: input, junction candidates, result. One operation
// a cycle is accepted while each gives at most one junction and the result
// is not stalled. An operation that closes two passing junctions holds the
// candidate stage until both have left. Reset (synchronous, rst_n low)
// clears the junction state and the stage valids and loads the register
// defaults. A stalled result holds the candidate and input stages behind it.
module cigar_splice_junction_extractor_top
  import cse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cse_in_if.sink                in_ch,
  cse_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [ANCHOR_W-1:0] min_anchor_r;
  logic [INTRON_W-1:0] min_intron_r, max_intron_r;

  logic  s0_vld_r;
  item_t s0_item_r;
  logic  s1_free, s0_adv;
  cand_t cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_anchor_r <= MIN_ANCHOR_RST;
      min_intron_r <= MIN_INTRON_RST;
      max_intron_r <= MAX_INTRON_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MIN_ANCHOR: min_anchor_r <= cfg_wdata[ANCHOR_W-1:0];
        CFG_MIN_INTRON: min_intron_r <= cfg_wdata[INTRON_W-1:0];
        CFG_MAX_INTRON: max_intron_r <= cfg_wdata[INTRON_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s0_adv      = s0_vld_r && s1_free;
  assign in_ch.ready = !s0_vld_r || s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s0_vld_r <= 1'b1;
    end else if (s1_free) begin
      s0_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_item_r <= '{align_pos:   in_ch.align_pos,
                     chrom_index: in_ch.chrom_index,
                     strand_code: in_ch.strand_code,
                     op_code:     in_ch.op_code,
                     op_length:   in_ch.op_length,
                     first_op:    in_ch.first_op,
                     last_op:     in_ch.last_op};
    end
  end

  cse_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (s0_item_r),
    .take  (s0_adv),
    .cand  (cand)
  );

  cse_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s0_adv),
    .cand       (cand),
    .min_anchor (min_anchor_r),
    .min_intron (min_intron_r),
    .max_intron (max_intron_r),
    .s1_free    (s1_free),
    .out_ch     (out_ch)
  );

  // hold a stalled operation in the input stage
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_vld_r && !s1_free |=> s0_vld_r && $stable(s0_item_r))
    else $error("input stage dropped a stalled operation");

  a_left_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.left_anchored |-> out_ch.junc_start >= out_ch.flank_start)
    else $error("left anchor flag set on negative overhang");

  a_right_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.right_anchored |-> out_ch.flank_end >= out_ch.junc_end)
    else $error("right anchor flag set on negative overhang");

  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s0_vld_r |-> in_ch.ready || s1_free)
    else $error("empty input stage refused a beat");

endmodule

@@ rtl/cse_track.sv @@
module cse_track
  import cse_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  item_t item,
  input  logic  take,
  output cand_t cand
);

  logic                inj_r, inj_nxt;
  pos_t                cur_start_r, cur_start_nxt;
  pos_t                cur_end_r, cur_end_nxt;
  pos_t                cur_fs_r, cur_fs_nxt;
  pos_t                cur_fe_r, cur_fe_nxt;
  logic [CHROM_W-1:0]  chrom_r, chrom_nxt;
  logic [STRAND_W-1:0] strand_r, strand_nxt;

  logic b_inj;
  pos_t b_start, b_end, b_fs, b_fe, sum, load_pos;

  always_comb begin
    load_pos = clamp_pos(item.align_pos);

    // State as seen after a possible first-operation load
    b_inj      = inj_r;
    b_start    = cur_start_r;
    b_end      = cur_end_r;
    b_fs       = cur_fs_r;
    b_fe       = cur_fe_r;
    chrom_nxt  = chrom_r;
    strand_nxt = strand_r;
    if (item.first_op) begin
      b_inj      = 1'b0;
      b_start    = load_pos;
      b_fs       = load_pos;
      b_end      = '0;
      b_fe       = '0;
      chrom_nxt  = item.chrom_index;
      strand_nxt = (item.strand_code == STRAND_RESERVED) ? STRAND_UNKNOWN
                                                        : item.strand_code;
    end

    // A skip restarts from the right flank, other ops extend it: same operand
    sum = sat_add(b_inj ? b_fe : b_start, item.op_length);

    inj_nxt       = b_inj;
    cur_start_nxt = b_start;
    cur_end_nxt   = b_end;
    cur_fs_nxt    = b_fs;
    cur_fe_nxt    = b_fe;
    cand.a_valid  = 1'b0;
    cand.b_valid  = 1'b0;
    cand.a        = '{j_start: b_start, j_end: b_end, f_start: b_fs, f_end: b_fe};

    if (!(item.first_op && item.last_op)) begin
      unique case (cigar_op_t'(item.op_code))
        OP_N: begin
          cand.a_valid = b_inj;
          if (b_inj) begin
            cur_fs_nxt    = b_end;
            cur_start_nxt = b_fe;
          end
          cur_end_nxt = sum;
          cur_fe_nxt  = sum;
          inj_nxt     = 1'b1;
        end
        OP_M, OP_D, OP_EQ, OP_X: begin
          if (b_inj) begin
            cur_fe_nxt = sum;
          end else begin
            cur_start_nxt = sum;
          end
        end
        default: begin
        end
      endcase
      if (item.last_op) begin
        cand.b_valid = inj_nxt;
        inj_nxt      = 1'b0;
      end
    end

    cand.b      = '{j_start: cur_start_nxt, j_end: cur_end_nxt,
                    f_start: cur_fs_nxt, f_end: cur_fe_nxt};
    cand.chrom  = chrom_nxt;
    cand.strand = strand_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r       <= 1'b0;
      cur_start_r <= '0;
      cur_end_r   <= '0;
      cur_fs_r    <= '0;
      cur_fe_r    <= '0;
      chrom_r     <= '0;
      strand_r    <= '0;
    end else if (take) begin
      inj_r       <= inj_nxt;
      cur_start_r <= cur_start_nxt;
      cur_end_r   <= cur_end_nxt;
      cur_fs_r    <= cur_fs_nxt;
      cur_fe_r    <= cur_fe_nxt;
      chrom_r     <= chrom_nxt;
      strand_r    <= strand_nxt;
    end
  end

endmodule

@@ rtl/cse_emit.sv @@
module cse_emit
  import cse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  cand_t               cand,
  input  logic [ANCHOR_W-1:0] min_anchor,
  input  logic [INTRON_W-1:0] min_intron,
  input  logic [INTRON_W-1:0] max_intron,
  output logic                s1_free,
  cse_out_if.source           out_ch
);

  logic  a_vld_r, b_vld_r;
  cand_t cand_r;

  logic                 out_vld_r;
  junc_t                out_j_r;
  logic [CHROM_W-1:0]   out_chrom_r;
  logic [STRAND_W-1:0]  out_strand_r;
  logic                 out_la_r, out_ra_r, out_last_r;

  logic  pass_a, pass_b, out_free, send;
  junc_t sel;

  assign pass_a   = a_vld_r && span_ok(cand_r.a, min_intron, max_intron);
  assign pass_b   = b_vld_r && span_ok(cand_r.b, min_intron, max_intron);
  assign out_free = !out_vld_r || out_ch.ready;
  assign send     = out_free && (pass_a || pass_b);
  // Free once at most one passing junction is left and it can leave now
  assign s1_free  = !(pass_a && pass_b) && (out_free || !(pass_a || pass_b));
  assign sel      = pass_a ? cand_r.a : cand_r.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (s1_free) begin
      a_vld_r <= load && cand.a_valid;
      b_vld_r <= load && cand.b_valid;
    end else if (send) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && load) begin
      cand_r <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (send) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_j_r      <= sel;
      out_chrom_r  <= cand_r.chrom;
      out_strand_r <= cand_r.strand;
      out_la_r     <= anchored(sel.j_start, sel.f_start, min_anchor);
      out_ra_r     <= anchored(sel.f_end, sel.j_end, min_anchor);
      out_last_r   <= !(pass_a && pass_b);
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.junc_chrom     = out_chrom_r;
  assign out_ch.junc_strand    = out_strand_r;
  assign out_ch.junc_start     = OUT_POS_W'(out_j_r.j_start);
  assign out_ch.junc_end       = OUT_POS_W'(out_j_r.j_end);
  assign out_ch.flank_start    = OUT_POS_W'(out_j_r.f_start);
  assign out_ch.flank_end      = OUT_POS_W'(out_j_r.f_end);
  assign out_ch.left_anchored  = out_la_r;
  assign out_ch.right_anchored = out_ra_r;
  assign out_ch.last_of_run    = out_last_r;

endmodule
